### sv/sha_pkg.sv
// ----------------------------------------------------------------------------
// SHA-256 shared definitions
// Round constants, initial hash value, sigma functions, sequencer state
// types and the control bundle between the byte sequencer and the core.
// ----------------------------------------------------------------------------
package sha_pkg;

   // Round constants, one per round.
   localparam logic [31:0] ROUND_K [0:63] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   // Initial hash value.
   localparam logic [31:0] INIT_HASH [0:7] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   localparam logic [7:0] PAD_BYTE      = 8'h80;
   localparam logic [5:0] LEN_POS       = 6'd56;
   localparam logic [5:0] LAST_POS      = 6'd63;
   localparam logic [5:0] LAST_ROUND    = 6'd63;
   localparam logic [2:0] LAST_WORD_IDX = 3'd7;

   // Byte sequencer states.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WAIT,
      ST_PAD,
      ST_OUT
   } hash_state_type;

   // Compression core states.
   typedef enum logic [1:0] {
      CORE_IDLE,
      CORE_ROUND,
      CORE_ADD
   } core_state_type;

   // Control bundle from the sequencer to the core.
   typedef struct packed {
      logic        push;    // shift a message word into the schedule window
      logic        start;   // the pushed word closes the block: compress it
      logic        rewind;  // return the chaining value to the initial hash
      logic [31:0] word;
   } sha_ctrl_type;

   function automatic logic [31:0] big_sigma0(input logic [31:0] x);
      big_sigma0 = {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
   endfunction

   function automatic logic [31:0] big_sigma1(input logic [31:0] x);
      big_sigma1 = {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
   endfunction

   function automatic logic [31:0] small_sigma0(input logic [31:0] x);
      small_sigma0 = {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
   endfunction

   function automatic logic [31:0] small_sigma1(input logic [31:0] x);
      small_sigma1 = {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
   endfunction

endpackage

### sv/sha_core.sv
// ----------------------------------------------------------------------------
// SHA-256 compression core
// Holds the 16-word message schedule window, the eight working variables
// and the chaining value. One round per cycle through the 64 rounds, then
// a chain-add state that adds the working variables into the chaining value.
// ----------------------------------------------------------------------------
module sha_core
   import sha_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  sha_ctrl_type ctrl,
   input  logic [2:0]   word_sel,
   output logic [31:0]  chain_word,
   output logic         done
);

   core_state_type state_ff, state_in;
   logic [5:0]  rnd_ff, rnd_in;
   logic [31:0] win_ff [0:15];
   logic [31:0] win_in [0:15];
   logic [31:0] v_ff [0:7];
   logic [31:0] v_in [0:7];
   logic [31:0] chain_ff [0:7];
   logic [31:0] chain_in [0:7];
   logic        round_en;
   logic        add_en;
   logic [31:0] sched_word;
   logic [31:0] t1;
   logic [31:0] t2;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         CORE_IDLE:  if (ctrl.start) state_in = CORE_ROUND;
         CORE_ROUND: if (rnd_ff == LAST_ROUND) state_in = CORE_ADD;
         CORE_ADD:   state_in = CORE_IDLE;
         default:    state_in = CORE_IDLE;
      endcase
   end

   // State outputs.
   always_comb begin
      round_en = 1'b0;
      add_en   = 1'b0;
      unique case (state_ff)
         CORE_IDLE:  ;
         CORE_ROUND: round_en = 1'b1;
         CORE_ADD:   add_en   = 1'b1;
         default:    ;
      endcase
   end

   assign done       = add_en;
   assign chain_word = chain_ff[word_sel];

   // Round and schedule arithmetic.
   always_comb begin
      sched_word = small_sigma1(win_ff[14]) + win_ff[9] + small_sigma0(win_ff[1]) + win_ff[0];
      t1 = v_ff[7] + big_sigma1(v_ff[4]) + ((v_ff[4] & v_ff[5]) ^ (~v_ff[4] & v_ff[6]))
         + ROUND_K[rnd_ff] + win_ff[0];
      t2 = big_sigma0(v_ff[0])
         + ((v_ff[0] & v_ff[1]) ^ (v_ff[0] & v_ff[2]) ^ (v_ff[1] & v_ff[2]));
   end

   // Schedule window: loaded by pushes while idle, self-extending in rounds.
   always_comb begin
      for (int i = 0; i < 16; i++) begin
         win_in[i] = win_ff[i];
      end
      if (ctrl.push || round_en) begin
         for (int i = 0; i < 15; i++) begin
            win_in[i] = win_ff[i + 1];
         end
         win_in[15] = round_en ? sched_word : ctrl.word;
      end
   end

   // Working variables.
   always_comb begin
      for (int i = 0; i < 8; i++) begin
         v_in[i] = v_ff[i];
      end
      if (ctrl.start) begin
         for (int i = 0; i < 8; i++) begin
            v_in[i] = chain_ff[i];
         end
      end else if (round_en) begin
         v_in[0] = t1 + t2;
         v_in[1] = v_ff[0];
         v_in[2] = v_ff[1];
         v_in[3] = v_ff[2];
         v_in[4] = v_ff[3] + t1;
         v_in[5] = v_ff[4];
         v_in[6] = v_ff[5];
         v_in[7] = v_ff[6];
      end
   end

   // Chaining value.
   always_comb begin
      for (int i = 0; i < 8; i++) begin
         if (ctrl.rewind) begin
            chain_in[i] = INIT_HASH[i];
         end else if (add_en) begin
            chain_in[i] = chain_ff[i] + v_ff[i];
         end else begin
            chain_in[i] = chain_ff[i];
         end
      end
   end

   assign rnd_in = round_en ? rnd_ff + 6'd1 : 6'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CORE_IDLE;
         rnd_ff   <= 6'd0;
         for (int i = 0; i < 8; i++) begin
            chain_ff[i] <= INIT_HASH[i];
         end
      end else begin
         state_ff <= state_in;
         rnd_ff   <= rnd_in;
         for (int i = 0; i < 8; i++) begin
            chain_ff[i] <= chain_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      win_ff <= win_in;
      v_ff   <= v_in;
   end

`ifndef SYNTH
   // A block may only start while the core is idle.
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      ctrl.start |-> state_ff == CORE_IDLE)
      else $error("block start while core busy");

   // The schedule window is not loaded during compression.
   a_push_idle: assert property (@(posedge clock) disable iff (reset)
      ctrl.push |-> state_ff == CORE_IDLE)
      else $error("word push while core busy");

   // After the last round the chaining value is updated.
   a_round_end: assert property (@(posedge clock) disable iff (reset)
      (state_ff == CORE_ROUND && rnd_ff == LAST_ROUND) |=> state_ff == CORE_ADD)
      else $error("missing chain update after last round");
`endif

endmodule

### sv/sha256_message_hasher.sv
// ----------------------------------------------------------------------------
// SHA-256 message hasher
// Streaming byte-in hasher: packs bytes into schedule words, drives the
// compression core, inserts padding and length, and returns the digest.
// ----------------------------------------------------------------------------
// Requests: taken one per cycle while idle; a byte that completes a 64-byte
//   block stalls the request side during its compression (64 rounds plus
//   the chain add) in the single round unit of the compression core.
// End of message: pad bytes up to the block end, one or two compressions,
//   then eight digest transactions, one per cycle if taken.
// Reset (synchronous): idle, zero byte count, initial hash value loaded.
module sha256_message_hasher
   import sha_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] msg_byte
   input  logic        req_tuser,   // [0] has_byte
   input  logic        req_tlast,   // end_of_message
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] digest_word
   output logic [2:0]  rsp_tuser,   // [2:0] word_index
   output logic        rsp_tlast    // last_word
);

   hash_state_type state_ff, state_in;
   logic [60:0] count_ff, count_in;
   logic [23:0] word_ff, word_in;
   logic [63:0] len_ff, len_in;
   logic        two_blk_ff, two_blk_in;
   logic        pad_first_ff, pad_first_in;
   logic        end_pend_ff, end_pend_in;
   logic        final_ff, final_in;
   logic [2:0]  idx_ff, idx_in;

   logic         req_acc;
   logic         rsp_acc;
   logic         out_end;
   logic         ins_en;
   logic [7:0]   ins_byte;
   logic         len_byte;
   logic         blk_full;
   logic [5:0]   pos;
   logic         core_done;
   sha_ctrl_type ctrl;

   assign pos     = count_ff[5:0];
   assign req_acc = req_tvalid && req_tready;
   assign rsp_acc = rsp_tvalid && rsp_tready;
   assign out_end = rsp_acc && (idx_ff == LAST_WORD_IDX);

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               if (blk_full) state_in = ST_WAIT;
               else if (req_tlast) state_in = ST_PAD;
            end
         end
         ST_WAIT: begin
            if (core_done) begin
               if (final_ff) state_in = ST_OUT;
               else if (end_pend_ff) state_in = ST_PAD;
               else state_in = ST_IDLE;
            end
         end
         ST_PAD: if (blk_full) state_in = ST_WAIT;
         ST_OUT: if (out_end) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // State outputs: handshakes and the byte that enters the block.
   always_comb begin
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;
      ins_en     = 1'b0;
      ins_byte   = req_tdata;
      len_byte   = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            ins_en     = req_tvalid && req_tuser;
         end
         ST_WAIT: ;
         ST_PAD: begin
            ins_en = 1'b1;
            if (pad_first_ff) begin
               ins_byte = PAD_BYTE;
            end else if (pos >= LEN_POS && !two_blk_ff) begin
               len_byte = 1'b1;
               ins_byte = len_ff[63:56];
            end else begin
               ins_byte = 8'h00;
            end
         end
         ST_OUT: rsp_tvalid = 1'b1;
         default: ;
      endcase
   end

   assign blk_full = ins_en && (pos == LAST_POS);

   // Core control bundle.
   always_comb begin
      ctrl.push   = ins_en && (pos[1:0] == 2'b11);
      ctrl.start  = blk_full;
      ctrl.rewind = out_end;
      ctrl.word   = {word_ff, ins_byte};
   end

   // Byte count, word assembly and padding bookkeeping.
   always_comb begin
      count_in     = count_ff;
      word_in      = word_ff;
      len_in       = len_ff;
      two_blk_in   = two_blk_ff;
      pad_first_in = pad_first_ff;
      end_pend_in  = end_pend_ff;
      final_in     = final_ff;
      idx_in       = idx_ff;
      if (ins_en) begin
         count_in = count_ff + 61'd1;
         word_in  = {word_ff[15:0], ins_byte};
      end
      if (out_end) begin
         count_in = 61'd0;
      end
      if (req_acc) begin
         end_pend_in = req_tlast;
         if (req_tlast) begin
            len_in       = {count_in, 3'b000};
            two_blk_in   = (count_in[5:0] >= LEN_POS);
            pad_first_in = 1'b1;
         end
      end
      if (state_ff == ST_PAD) begin
         pad_first_in = 1'b0;
         if (len_byte) begin
            len_in = {len_ff[55:0], 8'h00};
         end
         if (blk_full) begin
            two_blk_in = 1'b0;
            final_in   = !two_blk_ff;
         end
      end
      if (rsp_acc) begin
         idx_in = idx_ff + 3'd1;
      end
      if (out_end) begin
         final_in    = 1'b0;
         end_pend_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= 61'd0;
         two_blk_ff   <= 1'b0;
         pad_first_ff <= 1'b0;
         end_pend_ff  <= 1'b0;
         final_ff     <= 1'b0;
         idx_ff       <= 3'd0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         two_blk_ff   <= two_blk_in;
         pad_first_ff <= pad_first_in;
         end_pend_ff  <= end_pend_in;
         final_ff     <= final_in;
         idx_ff       <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
      len_ff  <= len_in;
   end

   // Compression core.
   sha_core u_core (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (ctrl),
      .word_sel   (idx_ff),
      .chain_word (rsp_tdata),
      .done       (core_done)
   );

   assign rsp_tuser = idx_ff;
   assign rsp_tlast = (idx_ff == LAST_WORD_IDX);

`ifndef SYNTH
   // The core only finishes a block while the sequencer waits for it.
   a_done_wait: assert property (@(posedge clock) disable iff (reset)
      core_done |-> state_ff == ST_WAIT)
      else $error("core finished outside wait state");

   // A message byte advances the byte count by one.
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (req_acc && req_tuser) |=> count_ff == $past(count_ff) + 61'd1)
      else $error("byte count did not advance");

   // After the last digest word the next message starts from zero.
   a_count_clear: assert property (@(posedge clock) disable iff (reset)
      out_end |=> (count_ff == 61'd0 && state_ff == ST_IDLE))
      else $error("byte count not cleared after digest");
`endif

endmodule

### verif/tb_top.sv
// ----------------------------------------------------------------------------
// SHA-256 message hasher testbench
// Streams messages of many lengths into the hasher one byte per transaction
// and checks every digest word against a behavioral SHA-256 model that is
// updated as each request transaction is accepted. The tests cover the empty
// message, end markers with and without a byte, padding that fits and padding
// that spills into a second block, a long output stall and random traffic.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RANDOM_ITEMS     = 80;
   localparam int LONG_HOLD_CYCLES = 400;
   localparam int DRAIN_CYCLES     = 100;
   localparam int CYCLE_LIMIT      = 500000;

   localparam logic [7:0] PAD_MARK   = 8'h80;
   localparam int         LEN_OFFSET = 56;
   localparam int         BLOCK_END  = 63;

   localparam logic [31:0] ROUND_CONST [0:63] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   localparam logic [31:0] START_HASH [0:7] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   // Receiver readiness patterns.
   typedef enum logic [1:0] {
      RX_STEADY,
      RX_CHOPPY,
      RX_SLOW
   } rx_mode_type;

   typedef struct packed {
      logic [31:0] word;
      logic [2:0]  index;
      logic        last;
   } digest_word_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = 8'h00;   // [7:0] msg_byte
   logic        req_tuser  = 1'b0;    // [0] has_byte
   logic        req_tlast  = 1'b0;    // end_of_message
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;            // [31:0] digest_word
   logic [2:0]  rsp_tuser;            // [2:0] word_index
   logic        rsp_tlast;            // last_word

   // Hash model state.
   logic [31:0] hash_state [0:7];
   logic [7:0]  msg_block [0:63];
   logic [60:0] msg_len_bytes;

   digest_word_type expected_digest_q [$];

   int error_count   = 0;
   int items_sent    = 0;
   int burst_left    = 8;
   int cycle_count   = 0;
   int hold_requests = 0;
   int hold_served   = 0;
   int hold_left     = 0;
   int rx_mode_left  = 0;
   rx_mode_type rx_mode = RX_STEADY;

   sha256_message_hasher uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always #2 clock = ~clock;

   // ---------------------------------------------------------------------
   // Hash model
   // ---------------------------------------------------------------------

   function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
      return (x >> n) | (x << (32 - n));
   endfunction

   task automatic restart_hash();
      for (int i = 0; i < 8; i++) hash_state[i] = START_HASH[i];
      msg_len_bytes = '0;
   endtask

   // Runs the 64 rounds over the current block and folds it into the hash.
   task automatic compress_msg_block();
      logic [31:0] sched [0:63];
      logic [31:0] a, b, c, d, e, f, g, h, t1, t2, s0, s1;
      for (int i = 0; i < 16; i++)
         sched[i] = {msg_block[4*i], msg_block[4*i+1], msg_block[4*i+2], msg_block[4*i+3]};
      for (int i = 16; i < 64; i++) begin
         s0 = rotr(sched[i-15], 7) ^ rotr(sched[i-15], 18) ^ (sched[i-15] >> 3);
         s1 = rotr(sched[i-2], 17) ^ rotr(sched[i-2], 19) ^ (sched[i-2] >> 10);
         sched[i] = s1 + sched[i-7] + s0 + sched[i-16];
      end
      a = hash_state[0]; b = hash_state[1]; c = hash_state[2]; d = hash_state[3];
      e = hash_state[4]; f = hash_state[5]; g = hash_state[6]; h = hash_state[7];
      for (int i = 0; i < 64; i++) begin
         t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
              + ROUND_CONST[i] + sched[i];
         t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
         h = g; g = f; f = e; e = d + t1;
         d = c; c = b; b = a; a = t1 + t2;
      end
      hash_state[0] += a; hash_state[1] += b; hash_state[2] += c; hash_state[3] += d;
      hash_state[4] += e; hash_state[5] += f; hash_state[6] += g; hash_state[7] += h;
   endtask

   // Applies one accepted request transaction; an end marker queues the digest.
   task automatic hash_request(input logic [7:0] msg_byte, input logic has_byte,
                               input logic end_of_message);
      int unsigned fill;
      logic [63:0] bit_len;
      digest_word_type dw;
      if (has_byte) begin
         fill = 32'(msg_len_bytes[5:0]);
         msg_block[fill] = msg_byte;
         msg_len_bytes++;
         if (fill == BLOCK_END) compress_msg_block();
      end
      if (!end_of_message) return;

      // Pad byte and zero fill; spill into an extra block if the length won't fit.
      fill = 32'(msg_len_bytes[5:0]);
      msg_block[fill] = PAD_MARK;
      for (int i = fill + 1; i < 64; i++) msg_block[i] = 8'h00;
      if (fill >= LEN_OFFSET) begin
         compress_msg_block();
         for (int i = 0; i < LEN_OFFSET; i++) msg_block[i] = 8'h00;
      end
      bit_len = {msg_len_bytes, 3'b000};
      for (int i = 0; i < 8; i++) msg_block[LEN_OFFSET + i] = bit_len[63 - 8*i -: 8];
      compress_msg_block();

      for (int i = 0; i < 8; i++) begin
         dw.word  = hash_state[i];
         dw.index = i[2:0];
         dw.last  = (i == 7);
         expected_digest_q.push_back(dw);
      end
      restart_hash();
   endtask

   // ---------------------------------------------------------------------
   // Request side
   // ---------------------------------------------------------------------

   // Offers one transaction, waits for it to be taken, then maybe idles.
   task automatic send_item(input logic [7:0] msg_byte, input logic has_byte,
                            input logic end_of_message);
      req_tvalid <= 1'b1;
      req_tdata  <= msg_byte;
      req_tuser  <= has_byte;
      req_tlast  <= end_of_message;
      do @(posedge clock); while (req_tready !== 1'b1);
      hash_request(msg_byte, has_byte, end_of_message);
      if (has_byte || end_of_message) items_sent++;
      if (burst_left > 0) burst_left--;
      if (burst_left == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                  : $urandom_range(1, 12);
      end
   endtask

   // Sends a message of random bytes; the end marker rides on the last byte
   // or on a separate transaction without a byte.
   task automatic send_message(input int unsigned len, input bit end_on_byte);
      for (int unsigned i = 0; i < len; i++) begin
         if ($urandom_range(0, 11) == 0) send_item(8'($urandom), 1'b0, 1'b0);
         send_item(8'($urandom), 1'b1, end_on_byte && (i == len - 1));
      end
      if (!end_on_byte || len == 0) send_item(8'($urandom), 1'b0, 1'b1);
   endtask

   // ---------------------------------------------------------------------
   // Response side: checks each digest word and shapes rsp_tready.
   // ---------------------------------------------------------------------

   task automatic check_digest_word();
      digest_word_type dw;
      if (expected_digest_q.size() == 0) begin
         $error("digest word with nothing expected: word %h index %0d", rsp_tdata, rsp_tuser);
         error_count++;
         return;
      end
      dw = expected_digest_q.pop_front();
      if (rsp_tdata !== dw.word) begin
         $error("digest_word: expected %h, actual %h", dw.word, rsp_tdata);
         error_count++;
      end
      if (rsp_tuser !== dw.index) begin
         $error("word_index: expected %0d, actual %0d", dw.index, rsp_tuser);
         error_count++;
      end
      if (rsp_tlast !== dw.last) begin
         $error("last_word: expected %0b, actual %0b", dw.last, rsp_tlast);
         error_count++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) check_digest_word();

         // A long hold requested by a test starts here and is counted down.
         if (hold_served != hold_requests) begin
            hold_served = hold_requests;
            hold_left   = LONG_HOLD_CYCLES;
         end
         if (rx_mode_left == 0) begin
            rx_mode      = rx_mode_type'($urandom_range(0, 2));
            rx_mode_left = $urandom_range(20, 80);
         end else begin
            rx_mode_left--;
         end

         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            case (rx_mode)
               RX_STEADY: rsp_tready <= 1'b1;
               RX_CHOPPY: rsp_tready <= ($urandom_range(0, 1) == 1);
               default:   rsp_tready <= ($urandom_range(0, 3) == 0);
            endcase
         end
      end
   end

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // Short hand-picked messages: empty, end with and without a byte, byte
   // extremes, and transactions that carry neither byte nor end.
   task automatic test_directed_messages();
      send_item(8'hA5, 1'b0, 1'b0);
      send_item(8'hFF, 1'b0, 1'b1);
      send_item(8'h61, 1'b1, 1'b0);
      send_item(8'h62, 1'b1, 1'b0);
      send_item(8'h63, 1'b1, 1'b1);
      send_item(8'h61, 1'b1, 1'b0);
      send_item(8'h62, 1'b1, 1'b0);
      send_item(8'h63, 1'b1, 1'b0);
      send_item(8'h00, 1'b0, 1'b1);
      send_item(8'h00, 1'b1, 1'b0);
      send_item(8'hFF, 1'b1, 1'b1);
      send_item(8'hFF, 1'b1, 1'b0);
      send_item(8'h5A, 1'b0, 1'b0);
      send_item(8'h00, 1'b1, 1'b0);
      send_item(8'hFF, 1'b1, 1'b0);
      send_item(8'h00, 1'b0, 1'b0);
      send_item(8'hFF, 1'b0, 1'b1);
   endtask

   // Lengths where the length field just fits or just spills into a
   // second block.
   task automatic test_pad_boundaries();
      send_message(55, 1'b1);
      send_message(56, 1'b0);
   endtask

   // Output held off for a long stretch while messages keep coming, so the
   // hasher backs up and stalls its request side.
   task automatic test_output_backpressure();
      hold_requests++;
      send_message(2, 1'b1);
      send_message(0, 1'b0);
      send_message(5, 1'b0);
      send_message(3, 1'b1);
   endtask

   // Random messages, mostly short, some long and some on block boundaries.
   task automatic test_random_messages();
      int unsigned stop_at;
      int unsigned len;
      int unsigned pick;
      stop_at = items_sent + RANDOM_ITEMS;
      while (items_sent < stop_at) begin
         pick = $urandom_range(0, 9);
         if (pick < 7) begin
            len = $urandom_range(0, 20);
         end else if (pick < 9) begin
            len = $urandom_range(21, 70);
         end else begin
            case ($urandom_range(0, 7))
               0: len = 55;
               1: len = 56;
               2: len = 63;
               3: len = 64;
               4: len = 119;
               5: len = 120;
               6: len = 127;
               default: len = 128;
            endcase
         end
         send_message(len, $urandom_range(0, 1));
      end
   endtask

   // ---------------------------------------------------------------------
   // Sequence and end of run
   // ---------------------------------------------------------------------

   initial begin
      restart_hash();
      for (int i = 0; i < 64; i++) msg_block[i] = 8'h00;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed_messages();
      test_pad_boundaries();
      test_output_backpressure();
      test_random_messages();
      req_tvalid <= 1'b0;

      while (expected_digest_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   // Watchdog on total run length.
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule
